### hw/rtl/msp_pkg.sv
// Package for the multi-stack shared pool: sizes, codes, result struct and helpers.
// No dependencies; used by every file of the block but msp_ram.
package msp_pkg;

	localparam int POOL_ENTRIES = 32;
	localparam int STACK_COUNT  = 4;
	localparam int DATA_BITS    = 32;

	localparam int IDX_W   = $clog2(POOL_ENTRIES);
	localparam int CNT_W   = $clog2(POOL_ENTRIES + 1);
	localparam int SEL_W   = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
	localparam int ENTRY_W = IDX_W + DATA_BITS;

	localparam int OP_W     = 2;
	localparam int STKSEL_W = 4;
	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 6;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_TOP  = 2'd2
	} msp_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BAD   = 2'd3
	} msp_status_t;

	typedef struct packed {
		logic                start;
		logic                commit;
		logic [OP_W-1:0]     op;
		logic [STKSEL_W-1:0] sel;
		logic [WORD_W-1:0]   value;
	} msp_ctl_t;

	typedef struct packed {
		msp_status_t         status;
		logic [WORD_W-1:0]   top_value;
		logic [COUNT_W-1:0]  depth_now;
		logic [COUNT_W-1:0]  free_left;
		logic [CNT_W-1:0]    free_cnt;
	} msp_res_t;

	// power-on link of entry i: next entry, last wraps to zero
	function automatic logic [IDX_W-1:0] link_init(input logic [IDX_W-1:0] i);
		logic [IDX_W:0] nx;
		nx = {1'b0, i} + (IDX_W+1)'(1);
		return (nx < (IDX_W+1)'(POOL_ENTRIES)) ? nx[IDX_W-1:0] : '0;
	endfunction

	function automatic logic [DATA_BITS-1:0] fit_data(input logic [WORD_W-1:0] v);
		logic [DATA_BITS+WORD_W-1:0] w;
		w = {{DATA_BITS{1'b0}}, v};
		return w[DATA_BITS-1:0];
	endfunction

	function automatic logic [WORD_W-1:0] data_word(input logic [DATA_BITS-1:0] d);
		logic [DATA_BITS+WORD_W-1:0] w;
		w = {{WORD_W{1'b0}}, d};
		return w[WORD_W-1:0];
	endfunction

	function automatic logic [COUNT_W-1:0] count_out(input logic [CNT_W-1:0] c);
		logic [CNT_W+COUNT_W-1:0] w;
		w = {{COUNT_W{1'b0}}, c};
		return w[COUNT_W-1:0];
	endfunction

endpackage

### hw/rtl/msp_if.sv
// Request and response channel interfaces of the multi-stack shared pool.
// Depends on msp_pkg for field widths.
interface msp_req_if;
	logic                         valid;
	logic                         ready;
	logic [msp_pkg::OP_W-1:0]     op;
	logic [msp_pkg::STKSEL_W-1:0] stack_sel;
	logic [msp_pkg::WORD_W-1:0]   push_value;

	modport source (output valid, op, stack_sel, push_value, input ready);
	modport sink   (input valid, op, stack_sel, push_value, output ready);
endinterface

interface msp_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [msp_pkg::WORD_W-1:0]  top_value;
	logic [msp_pkg::COUNT_W-1:0] depth_now;
	logic [msp_pkg::COUNT_W-1:0] free_left;

	modport source (output valid, status, top_value, depth_now, free_left, input ready);
	modport sink   (input valid, status, top_value, depth_now, free_left, output ready);
endinterface

### hw/rtl/multi_stack_shared_pool_unit.sv
// Multi-stack shared pool, top level: request/response handshake and result register.
// Each request word reads its entry when accepted; the result is registered on commit,
// which waits while the previous response word is still held in the result register.
// A new word is accepted only once the previous read-then-write RAM pass has committed.
// Reset: all stacks empty, free list holds every entry in order; entry links read their
// power-on value through per-entry valid bits, so no clearing pass is needed.
// Depends on msp_pkg, msp_if and msp_engine.
module multi_stack_shared_pool_unit (
	input  logic       clk,
	input  logic       arst_n,
	msp_req_if.sink    req,
	msp_rsp_if.source  rsp
);
	msp_pkg::msp_ctl_t ctl;
	msp_pkg::msp_res_t res;

	logic busy_s1_q;
	logic rsp_valid_q;
	logic accept, commit;

	assign req.ready = !busy_s1_q;
	assign accept    = req.valid && req.ready;
	assign commit    = busy_s1_q && (!rsp_valid_q || rsp.ready);

	assign ctl.start  = accept;
	assign ctl.commit = commit;
	assign ctl.op     = req.op;
	assign ctl.sel    = req.stack_sel;
	assign ctl.value  = req.push_value;

	msp_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_s1_q <= 1'b1;
			end else if (commit) begin
				busy_s1_q <= 1'b0;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp.status    <= res.status;
			rsp.top_value <= res.top_value;
			rsp.depth_now <= res.depth_now;
			rsp.free_left <= res.free_left;
		end
	end

	assign rsp.valid = rsp_valid_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1_q && !commit |=> busy_s1_q)
		else $error("item left stage 1 without commit");

	a_bad_depth: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == msp_pkg::ST_BAD |-> rsp.depth_now == '0)
		else $error("bad stack number with nonzero depth");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res.free_cnt <= msp_pkg::CNT_W'(msp_pkg::POOL_ENTRIES))
		else $error("free count above pool size");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == msp_pkg::ST_FULL |-> rsp.free_left == '0)
		else $error("pool full reported with free entries");
endmodule

### hw/rtl/msp_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module msp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### hw/rtl/msp_engine.sv
// Pool engine: stack heads, counts, free list and the entry RAM (link + value).
// Reads one entry on start; on commit of a push or pop, writes it back and updates pointers.
// Depends on msp_pkg and msp_ram.
module msp_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  msp_pkg::msp_ctl_t ctl,
	output msp_pkg::msp_res_t res
);
	logic [msp_pkg::IDX_W-1:0]     stack_head_q  [msp_pkg::STACK_COUNT];
	logic [msp_pkg::CNT_W-1:0]     stack_count_q [msp_pkg::STACK_COUNT];
	logic [msp_pkg::IDX_W-1:0]     free_head_q;
	logic [msp_pkg::CNT_W-1:0]     free_count_q;
	logic [msp_pkg::POOL_ENTRIES-1:0] link_vld_q;

	logic [msp_pkg::OP_W-1:0]      op_s1;
	logic [msp_pkg::STKSEL_W-1:0]  sel_s1;
	logic [msp_pkg::DATA_BITS-1:0] val_s1;
	logic [msp_pkg::IDX_W-1:0]     addr_s1;

	logic                          in_s0, in_s1;
	logic [msp_pkg::SEL_W-1:0]     idx_s0, idx_s1;
	logic [msp_pkg::IDX_W-1:0]     raddr;
	logic [msp_pkg::ENTRY_W-1:0]   rd_entry, wdata;
	logic [msp_pkg::IDX_W-1:0]     link_rd;
	logic                          we, do_push, do_pop;
	logic [msp_pkg::CNT_W-1:0]     cnt_cur, cnt_nxt, free_nxt;

	assign in_s0  = ((msp_pkg::STKSEL_W+1)'(ctl.sel) < (msp_pkg::STKSEL_W+1)'(msp_pkg::STACK_COUNT));
	assign idx_s0 = ctl.sel[msp_pkg::SEL_W-1:0];
	assign raddr  = (ctl.op == msp_pkg::OP_PUSH || !in_s0) ? free_head_q : stack_head_q[idx_s0];

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_s1   <= ctl.op;
			sel_s1  <= ctl.sel;
			val_s1  <= msp_pkg::fit_data(ctl.value);
			addr_s1 <= raddr;
		end
	end

	msp_ram #(
		.WIDTH (msp_pkg::ENTRY_W),
		.DEPTH (msp_pkg::POOL_ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (wdata),
		.re    (ctl.start),
		.raddr (raddr),
		.rdata (rd_entry)
	);

	assign in_s1   = ((msp_pkg::STKSEL_W+1)'(sel_s1) < (msp_pkg::STKSEL_W+1)'(msp_pkg::STACK_COUNT));
	assign idx_s1  = sel_s1[msp_pkg::SEL_W-1:0];
	assign link_rd = link_vld_q[addr_s1] ? rd_entry[msp_pkg::ENTRY_W-1 -: msp_pkg::IDX_W]
		: msp_pkg::link_init(addr_s1);

	always_comb begin
		we            = 1'b0;
		do_push       = 1'b0;
		do_pop        = 1'b0;
		wdata         = '0;
		cnt_cur       = in_s1 ? stack_count_q[idx_s1] : '0;
		cnt_nxt       = cnt_cur;
		free_nxt      = free_count_q;
		res.status    = msp_pkg::ST_OK;
		res.top_value = '0;
		if (!in_s1) begin
			res.status = msp_pkg::ST_BAD;
		end else if (op_s1 == msp_pkg::OP_PUSH) begin
			if (free_count_q == '0) begin
				res.status = msp_pkg::ST_FULL;
			end else begin
				do_push  = 1'b1;
				we       = ctl.commit;
				wdata    = {stack_head_q[idx_s1], val_s1};
				cnt_nxt  = cnt_cur + msp_pkg::CNT_W'(1);
				free_nxt = free_count_q - msp_pkg::CNT_W'(1);
			end
		end else if (cnt_cur == '0) begin
			res.status = msp_pkg::ST_EMPTY;
		end else if (op_s1 == msp_pkg::OP_POP) begin
			do_pop   = 1'b1;
			we       = ctl.commit;
			wdata    = {free_head_q, {msp_pkg::DATA_BITS{1'b0}}};
			cnt_nxt  = cnt_cur - msp_pkg::CNT_W'(1);
			free_nxt = free_count_q + msp_pkg::CNT_W'(1);
		end else begin
			res.top_value = msp_pkg::data_word(rd_entry[msp_pkg::DATA_BITS-1:0]);
		end
		res.depth_now = msp_pkg::count_out(cnt_nxt);
		res.free_left = msp_pkg::count_out(free_nxt);
		res.free_cnt  = free_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < msp_pkg::STACK_COUNT; i++) begin
				stack_head_q[i]  <= '0;
				stack_count_q[i] <= '0;
			end
			free_head_q  <= '0;
			free_count_q <= msp_pkg::CNT_W'(msp_pkg::POOL_ENTRIES);
			link_vld_q   <= '0;
		end else if (ctl.commit) begin
			if (do_push) begin
				free_head_q          <= link_rd;
				stack_head_q[idx_s1] <= addr_s1;
			end
			if (do_pop) begin
				stack_head_q[idx_s1] <= link_rd;
				free_head_q          <= addr_s1;
			end
			if (do_push || do_pop) begin
				stack_count_q[idx_s1] <= cnt_nxt;
				free_count_q          <= free_nxt;
				link_vld_q[addr_s1]   <= 1'b1;
			end
		end
	end
endmodule

### verif/tb_multi_stack_shared_pool_unit.sv
// Self-checking testbench for multi_stack_shared_pool_unit: push, pop and top traffic
// on the shared pool, with each response word compared against a linked-list predictor.
// Depends on msp_pkg, msp_if (msp_req_if, msp_rsp_if) and the block's RTL.
module tb_multi_stack_shared_pool_unit;
	import msp_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int RANDOM_ITEMS = 1850;
	localparam int DRAIN_CYCLES = 4;
	localparam logic [OP_W-1:0] OP_TOP_ALIAS = 2'd3;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

	typedef struct {
		msp_status_t        status;
		logic [WORD_W-1:0]  top_value;
		logic [COUNT_W-1:0] depth_now;
		logic [COUNT_W-1:0] free_left;
	} pool_reply_t;

	class stack_pool_scoreboard;
		logic [IDX_W-1:0]     link_of [POOL_ENTRIES];
		logic [DATA_BITS-1:0] data_of [POOL_ENTRIES];
		logic [IDX_W-1:0]     head_of [STACK_COUNT];
		logic [CNT_W-1:0]     depth_of [STACK_COUNT];
		logic [IDX_W-1:0]     free_ptr;
		logic [CNT_W-1:0]     free_total;
		pool_reply_t          awaiting_replies[$];
		int                   errors;
		int                   by_status[4];

		function new();
			for (int i = 0; i < POOL_ENTRIES; i++) begin
				link_of[i] = (i + 1 < POOL_ENTRIES) ? IDX_W'(i + 1) : '0;
				data_of[i] = '0;
			end
			for (int s = 0; s < STACK_COUNT; s++) begin
				head_of[s] = '0;
				depth_of[s] = '0;
			end
			free_ptr = '0;
			free_total = CNT_W'(POOL_ENTRIES);
			errors = 0;
			for (int k = 0; k < 4; k++)
				by_status[k] = 0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		function void note_request(logic [OP_W-1:0] op, logic [STKSEL_W-1:0] sel,
				logic [WORD_W-1:0] value);
			pool_reply_t      r;
			int               s;
			logic [IDX_W-1:0] id;
			r.status = ST_OK;
			r.top_value = '0;
			r.depth_now = '0;
			if (int'(sel) >= STACK_COUNT) begin
				r.status = ST_BAD;
			end else begin
				s = int'(sel);
				if (op == OP_PUSH) begin
					if (free_total == 0) begin
						r.status = ST_FULL;
					end else begin
						id = free_ptr;
						free_ptr = link_of[id];
						link_of[id] = head_of[s];
						data_of[id] = DATA_BITS'(value);
						head_of[s] = id;
						depth_of[s]++;
						free_total--;
					end
				end else if (depth_of[s] == 0) begin
					r.status = ST_EMPTY;
				end else if (op == OP_POP) begin
					id = head_of[s];
					head_of[s] = link_of[id];
					link_of[id] = free_ptr;
					free_ptr = id;
					depth_of[s]--;
					free_total++;
				end else begin
					r.top_value = WORD_W'(data_of[head_of[s]]);
				end
				if (r.status != ST_EMPTY)
					r.depth_now = COUNT_W'(depth_of[s]);
			end
			r.free_left = COUNT_W'(free_total);
			by_status[r.status]++;
			awaiting_replies.push_back(r);
		endfunction

		task check_result(logic [1:0] status, logic [WORD_W-1:0] top_value,
				logic [COUNT_W-1:0] depth_now, logic [COUNT_W-1:0] free_left);
			pool_reply_t e;
			if (awaiting_replies.size() == 0) begin
				report($sformatf("response word with none pending (status %0d)", status));
			end else begin
				e = awaiting_replies.pop_front();
				if (status !== e.status)
					report($sformatf("status got %0d want %0d", status, e.status));
				if (top_value !== e.top_value)
					report($sformatf("top_value got %0h want %0h", top_value, e.top_value));
				if (depth_now !== e.depth_now)
					report($sformatf("depth_now got %0d want %0d", depth_now, e.depth_now));
				if (free_left !== e.free_left)
					report($sformatf("free_left got %0d want %0d", free_left, e.free_left));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet;
	int   rsp_hold = 0;

	msp_req_if req_ch();
	msp_rsp_if rsp_ch();

	stack_pool_scoreboard sb = new();

	multi_stack_shared_pool_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #10 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(16, 60);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (rsp_hold > 0) begin
			rsp_hold <= rsp_hold - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (!quiet && $urandom_range(0, 99) < 25)
				rsp_hold <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			sb.note_request(req_ch.op, req_ch.stack_sel, req_ch.push_value);
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.status, rsp_ch.top_value, rsp_ch.depth_now,
				rsp_ch.free_left);
	end

	task automatic send_request(logic [OP_W-1:0] op, logic [STKSEL_W-1:0] sel,
			logic [WORD_W-1:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.stack_sel <= sel;
		req_ch.push_value <= value;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic random_request(phase_t ph);
		int                  r;
		logic [OP_W-1:0]     op;
		logic [STKSEL_W-1:0] sel;
		logic [WORD_W-1:0]   value;
		r = $urandom_range(0, 99);
		case (ph)
			PH_FILL:  op = (r < 75) ? OP_PUSH : (r < 85) ? OP_POP : (r < 95) ? OP_TOP : OP_TOP_ALIAS;
			PH_DRAIN: op = (r < 15) ? OP_PUSH : (r < 80) ? OP_POP : (r < 95) ? OP_TOP : OP_TOP_ALIAS;
			default:  op = (r < 40) ? OP_PUSH : (r < 75) ? OP_POP : (r < 93) ? OP_TOP : OP_TOP_ALIAS;
		endcase
		if ($urandom_range(0, 99) < 8)
			sel = STKSEL_W'($urandom_range(STACK_COUNT, 15));
		else
			sel = STKSEL_W'($urandom_range(0, STACK_COUNT - 1));
		r = $urandom_range(0, 99);
		value = (r < 5) ? '0 : (r < 10) ? '1 : WORD_W'($urandom);
		send_request(op, sel, value);
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_multi_stack_shared_pool_unit failed");
		$finish;
	end

	initial begin
		int     sent;
		int     run_len;
		phase_t ph;
		arst_n = 1'b0;
		quiet = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_PUSH;
		req_ch.stack_sel = '0;
		req_ch.push_value = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stacks, out-of-range selects, value extremes, op code 3 as top
		send_request(OP_TOP, 4'd0, '0);
		send_request(OP_POP, 4'd0, '0);
		send_request(OP_TOP_ALIAS, 4'(STACK_COUNT - 1), '0);
		send_request(OP_PUSH, 4'(STACK_COUNT), 32'hFFFF_FFFF);
		send_request(OP_PUSH, 4'd15, 32'h1234_5678);
		send_request(OP_POP, 4'd7, '0);
		send_request(OP_TOP, 4'd15, '0);
		send_request(OP_TOP_ALIAS, 4'd9, '0);
		send_request(OP_PUSH, 4'd0, 32'h0000_0000);
		send_request(OP_PUSH, 4'd0, 32'hFFFF_FFFF);
		send_request(OP_TOP, 4'd0, '0);
		send_request(OP_TOP_ALIAS, 4'd0, '0);
		send_request(OP_POP, 4'd0, '0);
		send_request(OP_TOP, 4'd0, '0);
		send_request(OP_PUSH, 4'(STACK_COUNT - 1), 32'hA5A5_A5A5);
		send_request(OP_PUSH, 4'd1, 32'h5A5A_5A5A);
		send_request(OP_TOP, 4'(STACK_COUNT - 1), '0);
		send_request(OP_TOP, 4'd1, '0);
		send_request(OP_POP, 4'd0, '0);
		send_request(OP_POP, 4'd0, '0);
		send_request(OP_POP, 4'(STACK_COUNT - 1), '0);
		send_request(OP_POP, 4'd1, '0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			run_len = $urandom_range(40, 120);
			ph = phase_t'($urandom_range(0, 2));
			quiet = ($urandom_range(0, 99) < 25);
			for (int i = 0; i < run_len && sent < RANDOM_ITEMS; i++) begin
				random_request(ph);
				sent++;
			end
		end
		quiet = 1'b0;
		req_ch.valid <= 1'b0;

		while (sb.awaiting_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.awaiting_replies.size() != 0)
			sb.report("responses still pending at end of run");

		$display("covered %0d requests on %0d stacks sharing %0d entries",
			sent + 22, STACK_COUNT, POOL_ENTRIES);
		$display("status mix: ok %0d, pool full %0d, stack empty %0d, bad stack %0d",
			sb.by_status[ST_OK], sb.by_status[ST_FULL], sb.by_status[ST_EMPTY],
			sb.by_status[ST_BAD]);
		if (sb.errors == 0)
			$display("tb_multi_stack_shared_pool_unit passed");
		else
			$display("tb_multi_stack_shared_pool_unit failed");
		$finish;
	end
endmodule

### sim.f
hw/rtl/msp_pkg.sv
hw/rtl/msp_if.sv
hw/rtl/msp_ram.sv
hw/rtl/msp_engine.sv
hw/rtl/multi_stack_shared_pool_unit.sv
verif/tb_multi_stack_shared_pool_unit.sv
